/* hw/rtl/touch_gesture_recognizer_assert.svh */
// Assertion macros shared by the gesture recognizer RTL.
// Included by the modules that carry concurrent checks.
`ifndef TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define TGR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TGR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TGR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/tgr_pkg.sv */
// Package for the touch gesture recognizer: types, widths and codes.
// Used by every RTL module of the block; depends on nothing.
package tgr_pkg;
    localparam int SLOT_COUNT_DEF  = 16;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 4;
    localparam int LP_W   = 16;
    localparam int PX_W   = 12;
    localparam int DIST_W = 13;
    localparam int DX_W   = 13;
    localparam int KIND_W = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;
    localparam logic [1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [1:0] REG_DRAG_SLOP  = 2'd1;
    localparam logic [1:0] REG_STEP       = 2'd2;
    localparam logic [1:0] KIND_TAP  = 2'd0;
    localparam logic [1:0] KIND_PAN  = 2'd1;
    localparam logic [1:0] KIND_ZOOM = 2'd2;

    typedef enum logic [1:0] {MODE_IDLE, MODE_TAP, MODE_DRAG, MODE_PINCH} mode_t;
    typedef enum logic [2:0] {ST_COLLECT, ST_SQRT, ST_DECIDE, ST_EMIT} ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic start_sqrt;
        logic decide;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic emit;
    } status_t;
endpackage

/* hw/rtl/touch_gesture_recognizer.sv */
// Touch gesture recognizer top level: stream ports, config registers, output register.
// Depends on tgr_pkg, tgr_ctrl and tgr_datapath.
//
// Contacts enter on the s_axis channel, one beat per contact; tlast closes a frame,
// and a beat with contact_present (tuser) low is an empty frame that also closes it.
// tdata carries the slot, the position and frame_time_ms, which is taken from the
// beat that closes the frame.
// Non-closing beats do not hold the input. A closing beat holds the input while the
// differences are squared, the root is formed one bit per cycle and the decision is
// made, and when it produces a gesture also until the output register is loaded.
// At most one gesture beat leaves on m_axis per frame, once the output register is loaded.
// The configuration port writes the three thresholds at any edge with cfg_we high.
// Reset clears the tracking state and restores thresholds 500, 16 and 32.
// When m_axis stalls, the gesture waits in the output register while contacts keep
// flowing in; a following gesture then waits with s_axis_tready low until the
// output register has delivered its beat.
`include "touch_gesture_recognizer_assert.svh"
module touch_gesture_recognizer #(
    parameter int SLOT_COUNT  = tgr_pkg::SLOT_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // contact_slot[3:0], contact_x[15:4], contact_y[27:16], frame_time_ms[59:28],
    // zero[63:60]
    input  logic [tgr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    // contact_present
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tap_x[11:0], tap_y[23:12], long_press[24], zoom_dir[26:25],
    // pan_dx[39:27], pan_dy[52:40], zero[55:53]
    output logic [tgr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // gesture_kind
    output logic [tgr_pkg::KIND_W-1:0]    m_axis_tuser,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [tgr_pkg::LP_W-1:0]      cfg_data
);
    import tgr_pkg::*;

    logic [LP_W-1:0] long_press_reg;
    logic [PX_W-1:0] drag_slop_reg, step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LP_W'(500);
            drag_slop_reg <= PX_W'(16);
            step_reg <= PX_W'(32);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_DRAG_SLOP:  drag_slop_reg <= cfg_data[PX_W-1:0];
                REG_STEP:       step_reg <= cfg_data[PX_W-1:0];
                default:        long_press_reg <= long_press_reg;
            endcase
        end
    end

    cmd_t cmd;
    status_t status;
    logic out_load, out_valid_reg, in_close;
    logic [KIND_W-1:0] r_kind;
    logic [PX_W-1:0] r_tx, r_ty;
    logic r_long;
    logic [1:0] r_zoom;
    logic [DX_W-1:0] r_dx, r_dy;

    assign in_close = s_axis_tlast || !s_axis_tuser;

    tgr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_close(in_close), .in_ready(s_axis_tready),
        .out_load(out_load), .out_free(!out_valid_reg),
        .cmd(cmd), .status(status)
    );

    tgr_datapath #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .in_present(s_axis_tuser), .in_slot(s_axis_tdata[3:0]),
        .in_x(s_axis_tdata[15:4]), .in_y(s_axis_tdata[27:16]),
        .in_time(s_axis_tdata[28 +: TIME_W]),
        .long_press_ms(long_press_reg), .drag_slop_px(drag_slop_reg), .step_px(step_reg),
        .res_kind(r_kind), .res_tap_x(r_tx), .res_tap_y(r_ty), .res_long(r_long),
        .res_zoom(r_zoom), .res_dx(r_dx), .res_dy(r_dy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_axis_tuser <= r_kind;
            m_axis_tdata <= {3'd0, r_dy, r_dx, r_zoom, r_long, r_ty, r_tx};
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    `TGR_ASSERT_IMPL(a_load_when_free, clk, rst_n, out_load, !out_valid_reg)
    `TGR_ASSERT_NEXT(a_load_shows, clk, rst_n, out_load, m_axis_tvalid)
    `TGR_ASSERT_IMPL(a_no_intake_on_load, clk, rst_n, out_load, !s_axis_tready)
endmodule

/* hw/rtl/tgr_ctrl.sv */
// Sequencer of the gesture recognizer: collect contacts, run the square root, decide, emit.
// Depends on tgr_pkg and the assertion macro header.
`include "touch_gesture_recognizer_assert.svh"
module tgr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_close,
    output logic             in_ready,
    output logic             out_load,
    input  logic             out_free,
    output tgr_pkg::cmd_t    cmd,
    input  tgr_pkg::status_t status
);
    import tgr_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_close)
                    begin
                        cmd.start_sqrt = 1'b1;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                cmd.clear = 1'b1;
                state_next = status.emit ? ST_EMIT : ST_COLLECT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    `TGR_ASSERT_NEXT(a_close_starts_sqrt, clk, rst_n, in_valid && in_ready && in_close, state_reg == ST_SQRT)
    `TGR_ASSERT_IMPL(a_ready_only_collect, clk, rst_n, in_ready, state_reg == ST_COLLECT)
    `TGR_ASSERT_NEXT(a_decide_leaves, clk, rst_n, state_reg == ST_DECIDE, state_reg == ST_EMIT || state_reg == ST_COLLECT)
endmodule

/* hw/rtl/tgr_datapath.sv */
// Datapath of the gesture recognizer: frame capture, tracking state and a serial square root.
// Depends on tgr_pkg and the assertion macro header.
`include "touch_gesture_recognizer_assert.svh"
module tgr_datapath #(
    parameter int SLOT_COUNT  = tgr_pkg::SLOT_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tgr_pkg::cmd_t               cmd,
    output tgr_pkg::status_t            status,
    input  logic                        in_present,
    input  logic [tgr_pkg::SLOT_W-1:0]  in_slot,
    input  logic [tgr_pkg::PX_W-1:0]    in_x,
    input  logic [tgr_pkg::PX_W-1:0]    in_y,
    input  logic [tgr_pkg::TIME_W-1:0]  in_time,
    input  logic [tgr_pkg::LP_W-1:0]    long_press_ms,
    input  logic [tgr_pkg::PX_W-1:0]    drag_slop_px,
    input  logic [tgr_pkg::PX_W-1:0]    step_px,
    output logic [tgr_pkg::KIND_W-1:0]  res_kind,
    output logic [tgr_pkg::PX_W-1:0]    res_tap_x,
    output logic [tgr_pkg::PX_W-1:0]    res_tap_y,
    output logic                        res_long,
    output logic [1:0]                  res_zoom,
    output logic [tgr_pkg::DX_W-1:0]    res_dx,
    output logic [tgr_pkg::DX_W-1:0]    res_dy
);
    import tgr_pkg::*;

    localparam int CW = PX_W;
    localparam int RAD_W = 2 * CW + 2;
    localparam int ROOT_W = CW + 1;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    mode_t mode_reg;
    logic [SLOT_W-1:0] first_slot_reg, second_slot_reg;
    logic [CW-1:0] down_x_reg, down_y_reg, lk_x_reg, lk_y_reg, ls_x_reg, ls_y_reg;
    logic [TIME_W-1:0] down_time_reg, now_reg;
    logic [DIST_W-1:0] last_dist_reg;
    logic [1:0] fcount_reg;
    logic [SLOT_W-1:0] f_slot_reg [2];
    logic [CW-1:0] f_x_reg [2];
    logic [CW-1:0] f_y_reg [2];
    logic m1_v_reg, m2_v_reg, mo_v_reg;
    logic [CW-1:0] m1_x_reg, m1_y_reg, m2_x_reg, m2_y_reg, mo_x_reg, mo_y_reg;
    logic [SLOT_W-1:0] mo_slot_reg;

    logic [CW-1:0] in_xc, in_yc;
    logic contact;
    assign in_xc = in_x[CW-1:0];
    assign in_yc = in_y[CW-1:0];
    assign contact = in_present && ({{(32-SLOT_W){1'b0}}, in_slot} < 32'(SLOT_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg <= 2'd0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            mo_v_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            fcount_reg <= 2'd0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            mo_v_reg <= 1'b0;
        end
        else if (cmd.capture && contact)
        begin
            if (fcount_reg < 2'd2)
            begin
                fcount_reg <= fcount_reg + 2'd1;
            end
            if (!m1_v_reg && in_slot == first_slot_reg)
            begin
                m1_v_reg <= 1'b1;
            end
            if (!m2_v_reg && in_slot == second_slot_reg)
            begin
                m2_v_reg <= 1'b1;
            end
            if (!mo_v_reg && in_slot != first_slot_reg)
            begin
                mo_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && contact)
        begin
            if (fcount_reg < 2'd2)
            begin
                f_slot_reg[fcount_reg[0]] <= in_slot;
                f_x_reg[fcount_reg[0]] <= in_xc;
                f_y_reg[fcount_reg[0]] <= in_yc;
            end
            if (!m1_v_reg && in_slot == first_slot_reg)
            begin
                m1_x_reg <= in_xc;
                m1_y_reg <= in_yc;
            end
            if (!m2_v_reg && in_slot == second_slot_reg)
            begin
                m2_x_reg <= in_xc;
                m2_y_reg <= in_yc;
            end
            if (!mo_v_reg && in_slot != first_slot_reg)
            begin
                mo_slot_reg <= in_slot;
                mo_x_reg <= in_xc;
                mo_y_reg <= in_yc;
            end
        end
        if (cmd.capture)
        begin
            now_reg <= in_time;
        end
    end

    // Pick the one distance that the decision of this frame needs.
    logic [CW-1:0] ax, ay, bx, by;
    logic multi;
    assign multi = (fcount_reg == 2'd2) && mo_v_reg;
    always_comb
    begin
        ax = m1_x_reg;
        ay = m1_y_reg;
        bx = mo_x_reg;
        by = mo_y_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                ax = f_x_reg[0];
                ay = f_y_reg[0];
                bx = f_x_reg[1];
                by = f_y_reg[1];
            end
            MODE_TAP:
            begin
                if (!multi)
                begin
                    bx = down_x_reg;
                    by = down_y_reg;
                end
            end
            MODE_DRAG:
            begin
                if (!multi)
                begin
                    bx = ls_x_reg;
                    by = ls_y_reg;
                end
            end
            default:
            begin
                bx = m2_x_reg;
                by = m2_y_reg;
            end
        endcase
    end

    logic [CW-1:0] adx, ady;
    assign adx = (ax >= bx) ? ax - bx : bx - ax;
    assign ady = (ay >= by) ? ay - by : by - ay;

    // Squares are formed in the first sqrt cycle, then one root bit per cycle.
    logic [RAD_W-1:0] rem_reg, rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg, sq_reg;
    logic [2*CW-1:0] sqx, sqy;
    logic [RAD_W+1:0] trial;
    logic [RAD_W-1:0] rem_shift;

    assign sqx = adx * adx;
    assign sqy = ady * ady;
    assign rem_shift = {rem_reg[RAD_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial = {2'b00, rem_shift} - {{(RAD_W-ROOT_W){1'b0}}, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sq_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (cmd.start_sqrt)
        begin
            sq_reg <= 1'b1;
        end
        else if (sq_reg)
        begin
            sq_reg <= 1'b0;
            busy_reg <= 1'b1;
            cnt_reg <= CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_reg)
        begin
            rad_reg <= {2'b00, sqx} + {2'b00, sqy};
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (!trial[RAD_W+1])
            begin
                rem_reg <= trial[RAD_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign status.sqrt_done = busy_reg && cnt_reg == CNT_W'(1);

    // Decision at frame close.
    logic [DIST_W-1:0] d;
    logic [DIST_W:0] delta, mag;
    logic [TIME_W-1:0] held;
    logic emit;
    logic [KIND_W-1:0] kind;
    assign d = DIST_W'(root_reg);
    assign delta = {1'b0, d} - {1'b0, last_dist_reg};
    assign mag = delta[DIST_W] ? (~delta + 1'b1) : delta;
    assign held = now_reg - down_time_reg;

    always_comb
    begin
        emit = 1'b0;
        kind = KIND_TAP;
        case (mode_reg)
            MODE_TAP:
            begin
                emit = !m1_v_reg;
            end
            MODE_DRAG:
            begin
                if (m1_v_reg && !multi && {1'b0, d} >= {2'b00, step_px})
                begin
                    emit = 1'b1;
                    kind = KIND_PAN;
                end
            end
            MODE_PINCH:
            begin
                if (m1_v_reg && m2_v_reg && mag >= {2'b00, step_px})
                begin
                    emit = 1'b1;
                    kind = KIND_ZOOM;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end
    assign status.emit = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            first_slot_reg <= '0;
            second_slot_reg <= '0;
            down_x_reg <= '0;
            down_y_reg <= '0;
            lk_x_reg <= '0;
            lk_y_reg <= '0;
            ls_x_reg <= '0;
            ls_y_reg <= '0;
            down_time_reg <= '0;
            last_dist_reg <= '0;
        end
        else if (cmd.decide)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (fcount_reg == 2'd1)
                    begin
                        first_slot_reg <= f_slot_reg[0];
                        down_x_reg <= f_x_reg[0];
                        down_y_reg <= f_y_reg[0];
                        lk_x_reg <= f_x_reg[0];
                        lk_y_reg <= f_y_reg[0];
                        down_time_reg <= now_reg;
                        mode_reg <= MODE_TAP;
                    end
                    else if (fcount_reg == 2'd2)
                    begin
                        first_slot_reg <= f_slot_reg[0];
                        second_slot_reg <= f_slot_reg[1];
                        last_dist_reg <= d;
                        mode_reg <= MODE_PINCH;
                    end
                end
                MODE_TAP:
                begin
                    if (!m1_v_reg)
                    begin
                        mode_reg <= MODE_IDLE;
                    end
                    else
                    begin
                        lk_x_reg <= m1_x_reg;
                        lk_y_reg <= m1_y_reg;
                        if (multi)
                        begin
                            second_slot_reg <= mo_slot_reg;
                            last_dist_reg <= d;
                            mode_reg <= MODE_PINCH;
                        end
                        else if ({1'b0, d} >= {2'b00, drag_slop_px})
                        begin
                            ls_x_reg <= m1_x_reg;
                            ls_y_reg <= m1_y_reg;
                            mode_reg <= MODE_DRAG;
                        end
                    end
                end
                MODE_DRAG:
                begin
                    if (!m1_v_reg)
                    begin
                        mode_reg <= MODE_IDLE;
                    end
                    else if (multi)
                    begin
                        second_slot_reg <= mo_slot_reg;
                        last_dist_reg <= d;
                        mode_reg <= MODE_PINCH;
                    end
                    else if ({1'b0, d} >= {2'b00, step_px})
                    begin
                        ls_x_reg <= m1_x_reg;
                        ls_y_reg <= m1_y_reg;
                    end
                end
                default:
                begin
                    if (!m1_v_reg || !m2_v_reg)
                    begin
                        mode_reg <= MODE_IDLE;
                    end
                    else if (mag >= {2'b00, step_px})
                    begin
                        last_dist_reg <= d;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            res_kind <= kind;
            res_tap_x <= '0;
            res_tap_y <= '0;
            res_long <= 1'b0;
            res_zoom <= 2'b00;
            res_dx <= '0;
            res_dy <= '0;
            if (kind == KIND_TAP)
            begin
                res_tap_x <= PX_W'(lk_x_reg);
                res_tap_y <= PX_W'(lk_y_reg);
                res_long <= ({{(64-TIME_W){1'b0}}, held} >= 64'(long_press_ms));
            end
            else if (kind == KIND_PAN)
            begin
                res_dx <= DX_W'({1'b0, m1_x_reg} - {1'b0, ls_x_reg});
                res_dy <= DX_W'({1'b0, m1_y_reg} - {1'b0, ls_y_reg});
            end
            else
            begin
                res_zoom <= (!delta[DIST_W] && delta != '0) ? 2'b01 : 2'b11;
            end
        end
    end

    `TGR_ASSERT_NEXT(a_sqrt_square_first, clk, rst_n, cmd.start_sqrt, sq_reg && !busy_reg)
    `TGR_ASSERT_IMPL(a_no_capture_busy, clk, rst_n, busy_reg || sq_reg, !cmd.capture)
    `TGR_ASSERT_IMPL(a_count_limit, clk, rst_n, 1'b1, fcount_reg != 2'd3)
endmodule
